FILE: design/brrts_pkg.sv
// Shared types and constants for the budgeted round-robin tile streamer.
// No dependencies; every other design file imports this package.
package brrts_pkg;

  localparam int SLOT_COUNT_DEFAULT = 8;
  localparam int MAX_RESULTS        = 8;
  localparam int RESULT_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH        = 2;
  localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NO_FRAME = 8'hFF;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_BUDGET = 1'd1;

  // func codes of an input beat
  localparam logic [2:0] FUNC_REGISTER = 3'd0;
  localparam logic [2:0] FUNC_RELEASE  = 3'd1;
  localparam logic [2:0] FUNC_CLEAR    = 3'd2;
  localparam logic [2:0] FUNC_POST     = 3'd3;
  localparam logic [2:0] FUNC_VBLANK   = 3'd4;

  typedef enum logic [2:0] {
    OP_REGISTER,
    OP_RELEASE,
    OP_CLEAR,
    OP_POST,
    OP_VBLANK
  } cmd_op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  slot;
    logic [7:0]  frame;
    logic [7:0]  frame_tiles;
    logic [15:0] frame_offset;
    logic        still_live;
    logic [7:0]  frame_count;
    logic [7:0]  band_request;
    logic [7:0]  sheet_max_tiles;
    logic [7:0]  band_base;
    logic [7:0]  oam_page;
  } in_item_t;

  typedef struct packed {
    logic        is_copy;
    logic [2:0]  copy_slot;
    logic [7:0]  dest_tile;
    logic [7:0]  tile_count;
    logic [15:0] src_offset;
    logic        last;
  } out_item_t;

  // classified command passed from front end to back end
  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  slot;
    logic [7:0]  frame;
    logic [7:0]  frame_tiles;
    logic [15:0] frame_offset;
    logic        still_live;
    logic [7:0]  frame_count;
    logic [7:0]  band_size;
    logic [7:0]  band_base;
  } cmd_t;

endpackage

FILE: design/brrts_front.sv
// Front end: takes input beats, decodes func, gates vblanks and drops no-ops.
// Depends on brrts_pkg.
module brrts_front #(
  parameter int SLOT_COUNT = brrts_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  brrts_pkg::in_item_t in_data,
  input  logic                enabled,
  input  logic [7:0]          tile_budget,
  input  logic                q_full,
  output logic                q_push,
  output brrts_pkg::cmd_t     q_data
);
  import brrts_pkg::*;

  logic [7:0] prev_page;
  logic       accept;
  logic       in_range;
  logic       keep;
  logic       vblank_live;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign in_range    = int'(in_data.slot) < SLOT_COUNT;
  assign vblank_live = enabled && (in_data.oam_page != prev_page) && (tile_budget != 8'd0);

  always_comb begin
    q_data              = '0;
    q_data.slot         = in_data.slot;
    q_data.frame        = in_data.frame;
    q_data.frame_tiles  = in_data.frame_tiles;
    q_data.frame_offset = in_data.frame_offset;
    q_data.still_live   = in_data.still_live;
    q_data.frame_count  = in_data.frame_count;
    q_data.band_base    = in_data.band_base;
    q_data.band_size    = (in_data.band_request != 8'd0 &&
                           in_data.band_request < in_data.sheet_max_tiles)
                          ? in_data.band_request : in_data.sheet_max_tiles;
    keep = 1'b0;
    unique case (in_data.func)
      FUNC_REGISTER: begin
        q_data.op = OP_REGISTER;
        keep      = in_range;
      end
      FUNC_RELEASE: begin
        q_data.op = OP_RELEASE;
        keep      = in_range;
      end
      FUNC_CLEAR: begin
        q_data.op = OP_CLEAR;
        keep      = 1'b1;
      end
      FUNC_POST: begin
        q_data.op = OP_POST;
        keep      = in_range;
      end
      FUNC_VBLANK: begin
        q_data.op = OP_VBLANK;
        keep      = vblank_live;
      end
      default: begin
        q_data.op = OP_CLEAR;
        keep      = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

  // page tracking happens here so gated vblanks never reach the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_page <= 8'd0;
    end else if (accept && in_data.func == FUNC_VBLANK && enabled) begin
      prev_page <= in_data.oam_page;
    end
  end

endmodule

FILE: design/brrts_queue.sv
// Two-entry command queue between front end and back end.
// Depends on brrts_pkg.
module brrts_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  brrts_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output brrts_pkg::cmd_t pop_data
);
  import brrts_pkg::*;

  cmd_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full     = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/brrts_engine.sv
// Back end: slot table, table updates and the round-robin vblank walk.
// Holds the output register; depends on brrts_pkg.
module brrts_engine #(
  parameter int SLOT_COUNT = brrts_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           tile_budget,
  input  logic                 q_valid,
  input  brrts_pkg::cmd_t      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brrts_pkg::out_item_t out_data
);
  import brrts_pkg::*;

  localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int STEP_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;

  logic        slot_used          [SLOT_COUNT];
  logic [7:0]  slot_frame_count   [SLOT_COUNT];
  logic [7:0]  slot_band_size     [SLOT_COUNT];
  logic [7:0]  slot_band_base     [SLOT_COUNT];
  logic [7:0]  slot_shown_frame   [SLOT_COUNT];
  logic [7:0]  slot_wanted_frame  [SLOT_COUNT];
  logic [7:0]  slot_wanted_tiles  [SLOT_COUNT];
  logic [15:0] slot_wanted_offset [SLOT_COUNT];
  logic        slot_live          [SLOT_COUNT];

  logic [SW-1:0]           resume_slot;
  logic [SW-1:0]           cur;
  logic [STEP_W-1:0]       steps;
  logic [7:0]              budget;
  logic [RESULT_CNT_W-1:0] n_out;
  logic                    pend_valid;
  out_item_t               pend;

  logic [SW-1:0] cmd_slot;
  logic          can_push;
  logic          elig;
  logic [7:0]    n;
  logic          over;
  logic          defer;
  logic          emit;
  logic          step_go;
  logic          out_load;
  out_item_t     new_item;
  out_item_t     final_item;

  assign cmd_slot = SW'(q_data.slot);
  assign can_push = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    elig = slot_used[cur] && slot_live[cur] &&
           (slot_wanted_frame[cur] != slot_shown_frame[cur]) &&
           (slot_wanted_frame[cur] < slot_frame_count[cur]);
    n    = (slot_wanted_tiles[cur] > slot_band_size[cur])
           ? slot_band_size[cur] : slot_wanted_tiles[cur];
    over = n > budget;
    // over budget after something was spent, or result cap reached: defer
    defer = elig && ((over && (budget != tile_budget)) ||
                     (n != 8'd0 && n_out >= RESULT_CNT_W'(MAX_RESULTS)));
    emit    = elig && !defer && (n != 8'd0);
    step_go = !(emit && pend_valid && !can_push);

    out_load = ((state == S_WALK) && step_go && emit && pend_valid) ||
               ((state == S_DONE) && can_push);

    new_item            = '0;
    new_item.is_copy    = 1'b1;
    new_item.copy_slot  = 3'(cur);
    new_item.dest_tile  = slot_band_base[cur];
    new_item.tile_count = n;
    new_item.src_offset = slot_wanted_offset[cur];

    final_item      = pend_valid ? pend : out_item_t'('0);
    final_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      resume_slot <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used[i]          <= 1'b0;
        slot_frame_count[i]   <= 8'd0;
        slot_band_size[i]     <= 8'd0;
        slot_band_base[i]     <= 8'd0;
        slot_shown_frame[i]   <= 8'd0;
        slot_wanted_frame[i]  <= 8'd0;
        slot_wanted_tiles[i]  <= 8'd0;
        slot_wanted_offset[i] <= 16'd0;
        slot_live[i]          <= 1'b0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_data.op)
              OP_REGISTER: begin
                slot_used[cmd_slot]        <= 1'b1;
                slot_frame_count[cmd_slot] <= q_data.frame_count;
                slot_band_size[cmd_slot]   <= q_data.band_size;
                slot_band_base[cmd_slot]   <= q_data.band_base;
                slot_shown_frame[cmd_slot] <= NO_FRAME;
                slot_live[cmd_slot]        <= 1'b0;
              end
              OP_RELEASE: begin
                slot_used[cmd_slot] <= 1'b0;
              end
              OP_CLEAR: begin
                resume_slot <= '0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                  slot_used[i]          <= 1'b0;
                  slot_frame_count[i]   <= 8'd0;
                  slot_band_size[i]     <= 8'd0;
                  slot_band_base[i]     <= 8'd0;
                  slot_shown_frame[i]   <= 8'd0;
                  slot_wanted_frame[i]  <= 8'd0;
                  slot_wanted_tiles[i]  <= 8'd0;
                  slot_wanted_offset[i] <= 16'd0;
                  slot_live[i]          <= 1'b0;
                end
              end
              OP_POST: begin
                slot_wanted_frame[cmd_slot]  <= q_data.frame;
                slot_wanted_tiles[cmd_slot]  <= q_data.frame_tiles;
                slot_wanted_offset[cmd_slot] <= q_data.frame_offset;
                slot_live[cmd_slot]          <= q_data.still_live;
              end
              OP_VBLANK: begin
                cur    <= resume_slot;
                steps  <= '0;
                budget <= tile_budget;
                n_out  <= '0;
                state  <= S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (step_go) begin
            if (defer) begin
              resume_slot <= cur;
              state       <= S_DONE;
            end else begin
              if (elig) begin
                slot_shown_frame[cur] <= slot_wanted_frame[cur];
                budget                <= over ? 8'd0 : budget - n;
              end
              // hold each copy back one step so the final one can carry last
              if (emit) begin
                if (pend_valid) begin
                  out_data <= pend;
                end
                pend       <= new_item;
                pend_valid <= 1'b1;
                n_out      <= n_out + 1'b1;
              end
              if (steps == STEP_W'(SLOT_COUNT - 1)) begin
                state <= S_DONE;
              end
              steps <= steps + 1'b1;
              cur   <= (cur == SW'(SLOT_COUNT - 1)) ? '0 : cur + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (can_push) begin
            out_data   <= final_item;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/budgeted_round_robin_tile_streamer.sv
// Top level of the tile streamer: config registers, front end, queue, back end.
// Depends on brrts_pkg, brrts_front, brrts_queue and brrts_engine.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (brrts_pkg::in_item_t)
//   out      output     out_valid / out_ready  out_data  (brrts_pkg::out_item_t)
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// The front end takes one beat per cycle while the two-entry queue has room.
// Register, release, clear and post are each applied by the back end in its idle state.
// A vblank walk starts from the resume slot, visits the slots in turn through the slot
// table and closes with the last result; it stalls while out_ready is low.
// Synchronous reset clears the table at once.
module budgeted_round_robin_tile_streamer #(
  parameter int SLOT_COUNT = brrts_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  brrts_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output brrts_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [brrts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brrts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import brrts_pkg::*;

  logic       enabled;
  logic [7:0] tile_budget;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_in;
  cmd_t       q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      tile_budget <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED:     enabled     <= cfg_wdata[0];
        CFG_TILE_BUDGET: tile_budget <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  brrts_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .enabled     (enabled),
    .tile_budget (tile_budget),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  brrts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  brrts_engine #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .tile_budget (tile_budget),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: design/brrts_checker.sv
// Port-level checks for the tile streamer, bound onto the top level.
// Depends on brrts_pkg and budgeted_round_robin_tile_streamer.
module brrts_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input brrts_pkg::out_item_t out_data
);
  import brrts_pkg::*;

  // an end marker always closes its vblank
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_copy |-> out_data.last)
    else $error("end marker without last");

  a_marker_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_copy |->
      out_data.copy_slot == 3'd0 && out_data.dest_tile == 8'd0 &&
      out_data.tile_count == 8'd0 && out_data.src_offset == 16'd0)
    else $error("end marker carries copy fields");

  // zero-length copies are never issued
  a_copy_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_copy |-> out_data.tile_count != 8'd0)
    else $error("copy with zero tiles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

endmodule

bind budgeted_round_robin_tile_streamer brrts_checker u_brrts_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: verif/budgeted_round_robin_tile_streamer_tb.sv
// Self-checking testbench for budgeted_round_robin_tile_streamer: directed table, then
// random commands and refresh bursts, checked beat by beat against an in-bench predictor.
// Depends on brrts_pkg and the design files under design/.
module budgeted_round_robin_tile_streamer_tb;
  import brrts_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEFAULT;
  localparam int DRAIN_CYC   = 4 * (SLOTS + 2);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 50;
  localparam int PHASES      = 7;

  // func values the block does not decode
  localparam logic [2:0] FUNC_RSVD_LO  = 3'd5;
  localparam logic [2:0] FUNC_RSVD_MID = 3'd6;
  localparam logic [2:0] FUNC_RSVD_HI  = 3'd7;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t mark;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  budgeted_round_robin_tile_streamer #(.SLOT_COUNT(SLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  bit          cfg_on;
  logic [7:0]  cfg_budget;
  logic        sl_used       [SLOTS];
  logic [7:0]  sl_frames     [SLOTS];
  logic [7:0]  sl_band       [SLOTS];
  logic [7:0]  sl_base       [SLOTS];
  logic [7:0]  sl_shown      [SLOTS];
  logic [7:0]  sl_want_frame [SLOTS];
  logic [7:0]  sl_want_tiles [SLOTS];
  logic [15:0] sl_want_off   [SLOTS];
  logic        sl_live       [SLOTS];
  int unsigned next_slot;
  logic [7:0]  last_page;

  out_item_t   copy_beats [MAX_RESULTS];
  int          copy_cnt;
  out_item_t   pending_copies [$];

  plan_row_t   plan [$];
  bit          idling;
  int          sent;
  int unsigned mismatches;
  int unsigned cycles;
  out_item_t   want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls: mostly short, now and then long
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
          @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_copies.size() == 0) begin
        $error("copy beat with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        want = pending_copies.pop_front();
        check_field("is_copy", 16'(want.is_copy), 16'(out_data.is_copy));
        check_field("copy_slot", 16'(want.copy_slot), 16'(out_data.copy_slot));
        check_field("dest_tile", 16'(want.dest_tile), 16'(out_data.dest_tile));
        check_field("tile_count", 16'(want.tile_count), 16'(out_data.tile_count));
        check_field("src_offset", want.src_offset, out_data.src_offset);
        check_field("last", 16'(want.last), 16'(out_data.last));
      end
    end
  end

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      sl_used[i]       = 1'b0;
      sl_frames[i]     = '0;
      sl_band[i]       = '0;
      sl_base[i]       = '0;
      sl_shown[i]      = '0;
      sl_want_frame[i] = '0;
      sl_want_tiles[i] = '0;
      sl_want_off[i]   = '0;
      sl_live[i]       = 1'b0;
    end
    next_slot = 0;
  endtask

  // Applies one accepted command; copy_beats/copy_cnt hold the beats it causes.
  task automatic model_command(input in_item_t it);
    int unsigned s;
    int unsigned left;
    int unsigned n;
    copy_cnt = 0;
    case (it.func)
      FUNC_REGISTER: begin
        sl_used[it.slot]   = 1'b1;
        sl_frames[it.slot] = it.frame_count;
        sl_band[it.slot]   = (it.band_request != 0 && it.band_request < it.sheet_max_tiles) ?
                             it.band_request : it.sheet_max_tiles;
        sl_base[it.slot]   = it.band_base;
        sl_shown[it.slot]  = NO_FRAME;
        sl_live[it.slot]   = 1'b0;
      end
      FUNC_RELEASE: sl_used[it.slot] = 1'b0;
      FUNC_CLEAR:   clear_table();
      FUNC_POST: begin
        sl_want_frame[it.slot] = it.frame;
        sl_want_tiles[it.slot] = it.frame_tiles;
        sl_want_off[it.slot]   = it.frame_offset;
        sl_live[it.slot]       = it.still_live;
      end
      FUNC_VBLANK: begin
        if (cfg_on && it.oam_page != last_page) begin
          last_page = it.oam_page;
          if (cfg_budget != 0) begin
            left = 32'(cfg_budget);
            s    = next_slot % SLOTS;
            for (int k = 0; k < SLOTS; k++) begin
              if (sl_used[s] && sl_live[s] && sl_want_frame[s] != sl_shown[s] &&
                  sl_want_frame[s] < sl_frames[s]) begin
                n = 32'((sl_want_tiles[s] > sl_band[s]) ? sl_band[s] : sl_want_tiles[s]);
                // oversize: deferred unless it is the first thing copied
                if (n > left && left != cfg_budget) begin
                  next_slot = s;
                  break;
                end
                if (n > left) left = n;
                if (n != 0) begin
                  if (copy_cnt >= MAX_RESULTS) begin
                    next_slot = s;
                    break;
                  end
                  copy_beats[copy_cnt] = '{is_copy: 1'b1, copy_slot: 3'(s),
                                           dest_tile: sl_base[s], tile_count: 8'(n),
                                           src_offset: sl_want_off[s], last: 1'b0};
                  copy_cnt++;
                end
                sl_shown[s] = sl_want_frame[s];
                left -= n;
              end
              s = (s + 1) % SLOTS;
            end
            if (copy_cnt == 0) begin
              copy_beats[0] = '0;
              copy_cnt      = 1;
            end
            copy_beats[copy_cnt-1].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int idle_len();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at the edge of the previous accept (or later); leaves at this beat's accept.
  task automatic send(input in_item_t it, input bit typed = 1'b0, input out_item_t mark = '0);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    model_command(it);
    if (typed) pending_copies.push_back(mark);
    else for (int i = 0; i < copy_cnt; i++) pending_copies.push_back(copy_beats[i]);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_copies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic configure(input bit on, input logic [7:0] budget);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= CFG_DATA_W'(on);
    @(posedge clk);
    cfg_index <= CFG_TILE_BUDGET;
    cfg_wdata <= budget;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_on     = on;
    cfg_budget = budget;
  endtask

  // unused fields carry random bits
  function automatic in_item_t noise();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t reg_cmd(input logic [2:0] slot, input logic [7:0] fc,
                                       input logic [7:0] req, input logic [7:0] mx,
                                       input logic [7:0] base);
    in_item_t it;
    it = noise();
    it.func = FUNC_REGISTER;
    it.slot = slot;
    it.frame_count = fc;
    it.band_request = req;
    it.sheet_max_tiles = mx;
    it.band_base = base;
    return it;
  endfunction

  function automatic in_item_t post_cmd(input logic [2:0] slot, input logic [7:0] frame,
                                        input logic [7:0] tiles, input logic [15:0] off,
                                        input logic live);
    in_item_t it;
    it = noise();
    it.func = FUNC_POST;
    it.slot = slot;
    it.frame = frame;
    it.frame_tiles = tiles;
    it.frame_offset = off;
    it.still_live = live;
    return it;
  endfunction

  function automatic in_item_t vbl_cmd(input logic [7:0] page);
    in_item_t it;
    it = noise();
    it.func = FUNC_VBLANK;
    it.oam_page = page;
    return it;
  endfunction

  function automatic in_item_t bare_cmd(input logic [2:0] func, input logic [2:0] slot);
    in_item_t it;
    it = noise();
    it.func = func;
    it.slot = slot;
    return it;
  endfunction

  function automatic out_item_t closing_beat(input logic copy, input logic [2:0] slot,
                                             input logic [7:0] dest, input logic [7:0] cnt,
                                             input logic [15:0] off);
    return '{is_copy: copy, copy_slot: slot, dest_tile: dest, tile_count: cnt,
             src_offset: off, last: 1'b1};
  endfunction

  task automatic add_row(input in_item_t c, input bit typed = 1'b0, input out_item_t m = '0);
    plan_row_t r;
    r.cmd   = c;
    r.typed = typed;
    r.mark  = m;
    plan.push_back(r);
  endtask

  function automatic logic [7:0] pick_band_request();
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return 8'($urandom_range(1, 30));
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly frames inside the sheet and small tile counts, so walks do real work
  function automatic in_item_t random_command();
    in_item_t it;
    int r;
    it = noise();
    r  = $urandom_range(0, 99);
    if (r < 12) begin
      it.func = FUNC_REGISTER;
      it.band_request = pick_band_request();
      if ($urandom_range(0, 3) != 0) begin
        it.frame_count = 8'($urandom_range(1, 8));
        it.sheet_max_tiles = 8'($urandom_range(0, 40));
      end
    end else if (r < 16) begin
      it.func = FUNC_RELEASE;
    end else if (r < 18) begin
      it.func = FUNC_CLEAR;
    end else if (r < 62) begin
      it.func = FUNC_POST;
      if (sl_frames[it.slot] != 0 && $urandom_range(0, 4) != 0)
        it.frame = 8'($urandom_range(0, sl_frames[it.slot] - 1));
      if ($urandom_range(0, 3) != 0) it.frame_tiles = 8'($urandom_range(0, 24));
      it.still_live = ($urandom_range(0, 7) != 0);
    end else if (r < 95) begin
      it.func = FUNC_VBLANK;
      if ($urandom_range(0, 7) != 0) it.oam_page = last_page + 8'($urandom_range(1, 255));
    end else begin
      it.func = 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
    end
    return it;
  endfunction

  // new frame on every slot, then a vblank on a fresh page
  task automatic refresh_all();
    in_item_t it;
    for (int s = 0; s < SLOTS; s++) begin
      if (!sl_used[s] || sl_frames[s] == 0)
        send(reg_cmd(3'(s), 8'($urandom_range(1, 8)), pick_band_request(),
                     8'($urandom_range(1, 40)), 8'($urandom)));
      it = post_cmd(3'(s), 8'($urandom_range(0, sl_frames[s] - 1)),
                    8'($urandom_range(0, 24)), 16'($urandom), ($urandom_range(0, 9) != 0));
      send(it);
    end
    send(vbl_cmd(last_page + 8'($urandom_range(1, 255))));
  endtask

  initial begin
    out_item_t   no_copy;
    bit          on;
    logic [7:0]  bud;
    int          target;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    idling     = 1'b0;
    sent       = 0;
    mismatches = 0;
    cycles     = 0;
    cfg_on     = 1'b0;
    cfg_budget = '0;
    last_page  = '0;
    clear_table();
    no_copy = closing_beat(1'b0, 3'd0, 8'h00, 8'h00, 16'h0000);

    add_row(vbl_cmd(8'h00));                                  // page unchanged since reset
    add_row(vbl_cmd(8'h01), 1'b1, no_copy);                   // empty table
    add_row(reg_cmd(3'd0, 8'd4, 8'd0, 8'd8, 8'h10));          // band from sheet maximum
    add_row(post_cmd(3'd0, 8'd2, 8'd6, 16'h1234, 1'b1));
    add_row(vbl_cmd(8'h02), 1'b1, closing_beat(1'b1, 3'd0, 8'h10, 8'd6, 16'h1234));
    add_row(vbl_cmd(8'h03), 1'b1, no_copy);                   // frame already shown
    add_row(reg_cmd(3'd7, 8'd255, 8'd255, 8'd255, 8'hFF));
    add_row(post_cmd(3'd7, 8'd254, 8'd255, 16'hFFFF, 1'b1));
    // oversize but nothing spent yet: copied whole
    add_row(vbl_cmd(8'hFF), 1'b1, closing_beat(1'b1, 3'd7, 8'hFF, 8'd255, 16'hFFFF));
    add_row(post_cmd(3'd0, 8'd3, 8'd200, 16'h0000, 1'b1));    // clamped to band
    add_row(post_cmd(3'd7, 8'd0, 8'd12, 16'hABCD, 1'b1));
    add_row(reg_cmd(3'd3, 8'd2, 8'd5, 8'd10, 8'h40));         // band from request
    add_row(post_cmd(3'd3, 8'd1, 8'd9, 16'h0400, 1'b1));
    add_row(vbl_cmd(8'h10));                                  // slot 7 deferred
    add_row(vbl_cmd(8'h11));                                  // deferred slot goes first
    add_row(post_cmd(3'd3, 8'd2, 8'd3, 16'h0777, 1'b1));      // frame past sheet end
    add_row(post_cmd(3'd0, 8'd1, 8'd0, 16'h5555, 1'b1));      // zero tiles
    add_row(post_cmd(3'd7, 8'd5, 8'd4, 16'h0101, 1'b0));      // actor gone
    add_row(vbl_cmd(8'h12), 1'b1, no_copy);
    add_row(bare_cmd(FUNC_RELEASE, 3'd0));
    add_row(bare_cmd(FUNC_RSVD_LO, 3'd2));
    add_row(bare_cmd(FUNC_RSVD_MID, 3'd4));
    add_row(bare_cmd(FUNC_RSVD_HI, 3'd6));
    add_row(bare_cmd(FUNC_CLEAR, 3'd1));
    add_row(vbl_cmd(8'h13), 1'b1, no_copy);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    configure(1'b1, 8'd16);
    idling = 1'b1;
    foreach (plan[i]) send(plan[i].cmd, plan[i].typed, plan[i].mark);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin on = 1'b1; bud = 8'd255; end
        1: begin on = 1'b1; bud = 8'd1; end
        2: begin on = 1'b0; bud = 8'($urandom_range(1, 255)); end
        3: begin on = 1'b1; bud = 8'd0; end
        4: begin on = 1'b1; bud = 8'($urandom_range(2, 254)); end
        5: begin on = 1'b1; bud = 8'd255; end
        default: begin on = 1'b1; bud = 8'($urandom_range(8, 40)); end
      endcase
      settle();
      configure(on, bud);
      idling = !(p == 3 || p == 4);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0) refresh_all();
        else send(random_command());
      end
    end

    settle();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
